>>> design/tbd_pkg.sv
`timescale 1ns / 1ps

package tbd_pkg;

    // Largest block dimension the address space supports
    localparam int MAX_DIM_BLOCKS = 4096;
    // Coordinates clamp to this value
    localparam logic [15:0] SAT_LIM = (MAX_DIM_BLOCKS - 1 > 4095) ? 16'd4095
                                      : 16'(MAX_DIM_BLOCKS - 1);
    localparam int NUM_STAGES = 3;
    localparam int DIV_STEPS  = 12;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BPB    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] block_col;
        logic [11:0] block_row;
    } t_in;

    typedef struct packed {
        logic [11:0] dest_col;
        logic [11:0] dest_row;
        logic [31:0] byte_offset;
        logic        out_of_range;
    } t_out;

    typedef struct packed {
        logic [12:0] width_blocks;
        logic [12:0] height_blocks;
        logic [8:0]  bytes_per_block;
    } t_cfg;

    // One item in flight: coordinates and per-stage run flags
    typedef struct packed {
        logic [12:0]           col;
        logic [15:0]           row;
        logic [NUM_STAGES-1:0] run;
    } t_work;

    // Restoring divider state: partial remainder and dividend/quotient
    typedef struct packed {
        logic [11:0] rem;
        logic [11:0] quo;
    } t_div;

    typedef struct packed {
        t_work w;
        t_div  d;
    } t_rmp;

    // One quotient bit of a restoring division
    function automatic t_div div_step(t_div d, logic [11:0] n);
        t_div        res;
        logic [12:0] r2;
        logic        qb;
        r2 = {d.rem, d.quo[11]};
        qb = 1'b0;
        if (r2 >= {1'b0, n}) begin
            r2 = r2 - {1'b0, n};
            qb = 1'b1;
        end
        res.rem = r2[11:0];
        res.quo = {d.quo[10:0], qb};
        return res;
    endfunction

endpackage

>>> design/tbd_front.sv
`timescale 1ns / 1ps

module tbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tbd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_stall,
    input  tbd_pkg::t_in  i_data,
    input  logic          i_full,
    output logic          o_push,
    output tbd_pkg::t_work o_work
);
    import tbd_pkg::*;

    logic  r_fv;
    t_work r_fw;
    t_work n_fw;
    logic [12:0] w;
    logic [12:0] h;

    assign w = i_cfg.width_blocks;
    assign h = i_cfg.height_blocks;

    // Classify: decide which remap stages run for the current image
    always_comb begin
        n_fw.col    = {1'b0, i_data.block_col};
        n_fw.row    = {4'b0, i_data.block_row};
        n_fw.run[0] = (w > 13'd1) && (h > 13'd1) && ((w >> 1) != 13'd0);
        n_fw.run[1] = (w > 13'd2) && (h > 13'd2) && ((w >> 2) != 13'd0);
        n_fw.run[2] = (w > 13'd4) && (h > 13'd4) && ((w >> 3) != 13'd0);
    end

    assign o_stall = r_fv && i_full;
    assign o_push  = r_fv && !i_full;
    assign o_work  = r_fw;

    // Hold the item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (!r_fv || !i_full) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_fv || !i_full) && i_valid) begin
            r_fw <= n_fw;
        end
    end

endmodule

>>> design/tbd_queue.sv
`timescale 1ns / 1ps

module tbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbd_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tbd_pkg::t_work o_work
);
    import tbd_pkg::*;

    t_work           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (Q_AW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (Q_AW+1)'(1);
        end
    end

endmodule

>>> design/tbd_remap.sv
`timescale 1ns / 1ps

module tbd_remap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [1:0]     i_lvl,
    input  logic [12:0]    i_width,
    input  logic           i_valid,
    input  tbd_pkg::t_work i_work,
    output logic           o_valid,
    output tbd_pkg::t_work o_work
);
    import tbd_pkg::*;

    logic [11:0] n;
    logic [1:0]  hs;
    t_rmp        entry;
    t_rmp        pv    [DIV_STEPS];
    t_rmp        n_stg [DIV_STEPS];
    t_rmp        r_stg [DIV_STEPS];
    logic        r_v   [DIV_STEPS];
    logic        r_fin_v;
    t_work       r_fin;
    t_work       n_fin;
    t_rmp        last;
    logic [15:0] m;
    logic [12:0] p;
    logic [12:0] cm;
    logic [15:0] rm;
    logic [15:0] rowq;

    // Group count n = width / G, G = 2^lvl
    assign n  = 12'(i_width >> i_lvl);
    assign hs = i_lvl - 2'd1;

    always_comb begin
        entry.w     = i_work;
        entry.d.rem = '0;
        entry.d.quo = 12'(i_work.col >> i_lvl);
    end

    // Divider steps: one quotient bit per stage
    always_comb begin
        pv[0] = entry;
        for (int s = 1; s < DIV_STEPS; s++) pv[s] = r_stg[s-1];
        for (int s = 0; s < DIV_STEPS; s++) begin
            n_stg[s].w  = pv[s].w;
            n_stg[s].d  = div_step(pv[s].d, n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < DIV_STEPS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) r_stg[s] <= n_stg[s];
        end
    end

    // Rebuild coordinates from quotient and remainder of col/G by n
    always_comb begin
        last  = r_stg[DIV_STEPS-1];
        m     = 16'(last.w.row >> hs) + {4'b0, last.d.quo};
        p     = m[0] ? ({1'b0, n} + {1'b0, last.d.rem}) : {1'b0, last.d.rem};
        cm    = last.w.col & 13'((13'd1 << i_lvl) - 13'd1);
        rm    = last.w.row & ((16'd1 << hs) - 16'd1);
        rowq  = {m[15:1], 1'b0} + {15'b0, p[0]};
        n_fin = last.w;
        if (last.w.run[hs]) begin
            n_fin.col = 13'({4'b0, p[12:1]} << i_lvl) | cm;
            n_fin.row = (rowq << hs) | rm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (i_en) begin
            r_fin_v <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin <= n_fin;
        end
    end

    assign o_valid = r_fin_v;
    assign o_work  = r_fin;

endmodule

>>> design/tbd_back.sv
`timescale 1ns / 1ps

module tbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tbd_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  tbd_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output tbd_pkg::t_out  o_data
);
    import tbd_pkg::*;

    logic        en;
    logic        v   [NUM_STAGES+1];
    t_work       wk  [NUM_STAGES+1];
    logic [15:0] fcol;
    logic [15:0] frow;
    logic [11:0] sc;
    logic [11:0] sr;
    logic        oor;

    logic        r_m1_v;
    logic [24:0] r_m1_prod;
    logic [11:0] r_m1_col;
    logic [11:0] r_m1_row;
    logic        r_m1_oor;
    logic        r_m2_v;
    logic [25:0] r_m2_lin;
    logic [11:0] r_m2_col;
    logic [11:0] r_m2_row;
    logic        r_m2_oor;
    logic        r_out_v;
    t_out        r_out;
    logic [34:0] prod_off;

    // Whole pipeline advances when the output register is free
    assign en    = !r_out_v || !i_stall;
    assign o_pop = en && !i_empty;
    assign v[0]  = o_pop;
    assign wk[0] = i_work;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        tbd_remap u_remap (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lvl   (2'(g + 1)),
            .i_width (i_cfg.width_blocks),
            .i_valid (v[g]),
            .i_work  (wk[g]),
            .o_valid (v[g+1]),
            .o_work  (wk[g+1])
        );
    end

    // Range check and saturate
    always_comb begin
        fcol = {3'b0, wk[NUM_STAGES].col};
        frow = wk[NUM_STAGES].row;
        oor  = frow >= {3'b0, i_cfg.height_blocks};
        sc   = 12'((fcol > SAT_LIM) ? SAT_LIM : fcol);
        sr   = 12'((frow > SAT_LIM) ? SAT_LIM : frow);
    end

    assign prod_off = {9'b0, r_m2_lin} * {26'b0, i_cfg.bytes_per_block};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_m1_v  <= v[NUM_STAGES];
            r_m2_v  <= r_m1_v;
            r_out_v <= r_m2_v;
        end
    end

    // Offset: row * width, then add column, then scale by block size
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_prod <= {13'b0, sr} * {12'b0, i_cfg.width_blocks};
            r_m1_col  <= sc;
            r_m1_row  <= sr;
            r_m1_oor  <= oor;
            r_m2_lin  <= {1'b0, r_m1_prod} + {14'b0, r_m1_col};
            r_m2_col  <= r_m1_col;
            r_m2_row  <= r_m1_row;
            r_m2_oor  <= r_m1_oor;
            r_out.dest_col     <= r_m2_col;
            r_out.dest_row     <= r_m2_row;
            r_out.byte_offset  <= prod_off[31:0];
            r_out.out_of_range <= r_m2_oor;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

>>> design/texture_block_deswizzle_address.sv
`timescale 1ns / 1ps
// Texture block deswizzle address generator.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes the tiled column
// and row of one compressed block; a transfer happens when valid is high and
// stall is low. Output channel (o_out_valid / i_out_stall / o_out_data) gives
// the linear column, row, byte offset and out-of-range flag.
// The configuration channel (i_cfg_valid / o_cfg_ready, index and data) sets
// width, height and bytes per block; write it only while no item is in flight.
// One item per cycle is sustained while the receiver does not stall. From input
// transfer to output an item passes one front register, the queue, three remap
// stages (each a 12-step restoring divider by width/G plus a rebuild register)
// and three offset stages (two multiplies and an add).
// A 4-entry queue parts the front from the back; when the receiver stalls the
// back pipeline freezes, the queue fills and then input stall rises.
// Synchronous reset empties the pipeline and queue and loads width 1,
// height 1 and 16 bytes per block.
module texture_block_deswizzle_address (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tbd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tbd_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [12:0]   i_cfg_data
);
    import tbd_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_work f_work;
    t_work q_work;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_blocks    <= 13'd1;
            r_cfg.height_blocks   <= 13'd1;
            r_cfg.bytes_per_block <= 9'd16;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width_blocks    <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height_blocks   <= i_cfg_data;
                CFG_BPB:    r_cfg.bytes_per_block <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    tbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_work  (f_work)
    );

    tbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (f_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_work  (q_work)
    );

    tbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_work  (q_work),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

>>> design/tbd_checker.sv
`timescale 1ns / 1ps

module tbd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input tbd_pkg::t_out o_out_data,
    input logic          o_cfg_ready
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties the front register, so input is not stalled
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // Configuration is always taken
    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration not ready");

endmodule

bind texture_block_deswizzle_address tbd_checker u_tbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

>>> verif/texture_block_deswizzle_address_test.sv
`timescale 1ns / 1ps

module texture_block_deswizzle_address_test;
    import tbd_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    // Predictor copy of the registers
    logic [12:0] width_q = 13'd1;
    logic [12:0] height_q = 13'd1;
    logic [8:0]  bpb_q = 9'd16;

    t_in  coord_queue[$];
    t_out addr_expected[$];
    int   error_count = 0;
    int   result_count = 0;
    int   idle_calm = 0;
    int   hold_sender = 0;
    int   quiet_cycles = 0;
    bit   run_done = 1'b0;

    texture_block_deswizzle_address u_top (.*);

    always #2 i_clk = ~i_clk;

    // Compute the linear address of one tiled block
    function automatic t_out deswizzle(t_in c);
        t_out   r;
        longint col, row, g, h, n, t, p, u;
        bit     oor;
        col = c.block_col;
        row = c.block_row;
        for (g = 2; g <= 8; g = g * 2) begin
            h = g / 2;
            n = width_q / g;
            if (width_q > h && height_q > h && n != 0) begin
                t = col / g + (row / h) * n;
                p = t % (2 * n);
                u = (t - p) + p / 2 + (p % 2) * n;
                col = (u % n) * g + col % g;
                row = (u / n) * h + row % h;
            end
        end
        oor = row >= height_q;
        if (col > SAT_LIM) col = SAT_LIM;
        if (row > SAT_LIM) row = SAT_LIM;
        r.dest_col = col[11:0];
        r.dest_row = row[11:0];
        r.byte_offset = 32'(bpb_q * (row * width_q + col));
        r.out_of_range = oor;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    function automatic bit idle_now();
        return idle_calm == 0 && $urandom_range(99) < 32;
    endfunction

    // Drive input transfers from the pending queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                t_out exp_r;
                exp_r = deswizzle(i_in_data);
                addr_expected = {addr_expected, exp_r};
                void'(coord_queue.pop_front());
            end
            if (coord_queue.size() > 0 && !(i_in_valid && o_in_stall)) begin
                if (hold_sender == 0 && !idle_now()) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= coord_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (coord_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end
            i_out_stall <= idle_now();
        end
    end

    // Check output transfers against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                result_count <= result_count + 1;
                if (addr_expected.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    t_out w;
                    w = addr_expected.pop_front();
                    if (o_out_data.dest_col !== w.dest_col)
                        report_mismatch("dest_col", o_out_data.dest_col, w.dest_col);
                    if (o_out_data.dest_row !== w.dest_row)
                        report_mismatch("dest_row", o_out_data.dest_row, w.dest_row);
                    if (o_out_data.byte_offset !== w.byte_offset)
                        report_mismatch("byte_offset", o_out_data.byte_offset,
                                        w.byte_offset);
                    if (o_out_data.out_of_range !== w.out_of_range)
                        report_mismatch("out_of_range", o_out_data.out_of_range,
                                        w.out_of_range);
                end
            end
            if (!run_done && quiet_cycles > STALL_LIMIT) begin
                $display("timeout: %0d results still expected", addr_expected.size());
                $display("texture_block_deswizzle_address_test: errors");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (coord_queue.size() > 0 || addr_expected.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [12:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_q = val;
            CFG_HEIGHT: height_q = val;
            default:    bpb_q = val[8:0];
        endcase
    endtask

    task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] b);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_BPB, b);
    endtask

    task automatic push_coord(logic [11:0] c, logic [11:0] r);
        t_in it;
        it.block_col = c;
        it.block_row = r;
        coord_queue = {coord_queue, it};
    endtask

    // Mostly coordinates inside or just past the image, some anywhere in the field
    task automatic push_random(int count);
        logic [11:0] c, r;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                c = 12'($urandom);
                r = 12'($urandom);
            end else begin
                c = 12'($urandom_range(width_q > 0 ? width_q - 1 : 0));
                r = 12'($urandom_range(height_q + 1));
            end
            push_coord(c, r);
        end
    endtask

    initial begin
        int phase;
        logic [12:0] w, h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry, then the field extremes
        push_coord(12'd0, 12'd0);
        push_coord(12'd4095, 12'd4095);
        push_coord(12'd0, 12'd1);
        wait_drained();
        set_geometry(13'd64, 13'd32, 13'd16);
        push_coord(12'd0, 12'd0);
        push_coord(12'd63, 12'd31);
        push_coord(12'd5, 12'd32);
        push_coord(12'd4095, 12'd4095);
        push_coord(12'hAAA, 12'h555);
        push_coord(12'h555, 12'hAAA);
        wait_drained();
        // Narrow stages: width 3 lets the group of 4 and 8 pass unchanged
        set_geometry(13'd3, 13'd9, 13'd8);
        push_coord(12'd2, 12'd7);
        push_coord(12'd1, 12'd8);
        wait_drained();
        // Zero width, zero height, zero bytes
        set_geometry(13'd0, 13'd0, 13'd0);
        push_coord(12'd100, 12'd7);
        wait_drained();
        set_geometry(13'd0, 13'd5, 13'd256);
        push_coord(12'd4095, 12'd3);
        wait_drained();
        // Largest and out-of-range register values
        set_geometry(13'd4096, 13'd4096, 13'd256);
        push_coord(12'd4095, 12'd4095);
        push_coord(12'd1234, 12'd3210);
        wait_drained();
        set_geometry(13'h1FFF, 13'h1FFF, 13'h1FF);
        push_coord(12'd4095, 12'd4095);
        push_coord(12'd17, 12'd9);
        wait_drained();

        // Random phases over varied geometry; an early one runs with no idling
        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin w = 13'($urandom_range(1, 16)); h = 13'($urandom_range(1, 16)); end
                1: begin w = 13'($urandom_range(1, 4096)); h = 13'($urandom_range(1, 4096)); end
                2: begin w = 13'(1 << $urandom_range(12)); h = 13'(1 << $urandom_range(12)); end
                default: begin w = 13'($urandom); h = 13'($urandom); end
            endcase
            set_geometry(w, h, 13'($urandom_range(0, 511)));
            idle_calm = (phase == 1) ? 1 : 0;
            push_random(125);
            if (phase == 5) begin
                while (coord_queue.size() > 60) @(posedge i_clk);
                hold_sender = 1;
                while (addr_expected.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end
        idle_calm = 0;
        wait_drained();
        run_done = 1'b1;

        $display("covered %0d results over directed corner geometry and 12 random phases",
                 result_count);
        if (error_count == 0) begin
            $display("texture_block_deswizzle_address_test: clean");
        end else begin
            $display("texture_block_deswizzle_address_test: errors");
        end
        $finish;
    end

endmodule
